// ===== rtl/cube_map_face_select_assert.svh =====
// Assertion macros shared by the cube map face selection RTL.
`ifndef CUBE_MAP_FACE_SELECT_ASSERT_SVH
`define CUBE_MAP_FACE_SELECT_ASSERT_SVH

// Whenever the antecedent holds at a clock edge, the consequent holds at the same edge.
`define CMFS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cube map face select: check failed");

// Whenever the antecedent holds at a clock edge, the consequent holds at the next edge.
`define CMFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cube map face select: check failed");

`endif

// ===== rtl/cmfs_pkg.sv =====
// Shared widths, face codes and stage records for the cube map face selection block.
package cmfs_pkg;

   localparam int COMPONENT_BITS      = 16;
   localparam int COORD_FRACTION_BITS = 16;
   localparam int COORD_BITS          = COORD_FRACTION_BITS + 1;

   localparam int REQ_DATA_BITS = ((3 * COMPONENT_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((3 + 2 * COORD_BITS + 7) / 8) * 8;

   localparam logic [COORD_BITS-1:0] COORD_HALF = COORD_BITS'(1) << (COORD_FRACTION_BITS - 1);
   localparam logic [COORD_BITS-1:0] COORD_ONE  = COORD_BITS'(1) << COORD_FRACTION_BITS;

   typedef enum logic [2:0] {
      FACE_POS_X = 3'd0,
      FACE_NEG_X = 3'd1,
      FACE_POS_Y = 3'd2,
      FACE_NEG_Y = 3'd3,
      FACE_NEG_Z = 3'd4,
      FACE_POS_Z = 3'd5
   } face_type;

   // One request as it travels down the divider chain.
   typedef struct packed {
      face_type                          face;
      logic                              zero;
      logic                              u_sub;
      logic                              v_sub;
      logic [COMPONENT_BITS-1:0]         major;
      logic [COMPONENT_BITS-1:0]         rem_u;
      logic [COMPONENT_BITS-1:0]         rem_v;
      logic [COORD_FRACTION_BITS-1:0]    quo_u;
      logic [COORD_FRACTION_BITS-1:0]    quo_v;
   } stage_type;

   typedef struct packed {
      face_type                face;
      logic                    zero;
      logic [COORD_BITS-1:0]   coord_u;
      logic [COORD_BITS-1:0]   coord_v;
   } result_type;

endpackage

// ===== rtl/cmfs_select.sv =====
// Front stage: picks the major axis and face, and sets up both divisions.
module cmfs_select
   import cmfs_pkg::*;
(
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic signed [COMPONENT_BITS-1:0]  dir_x,
   input  logic signed [COMPONENT_BITS-1:0]  dir_y,
   input  logic signed [COMPONENT_BITS-1:0]  dir_z,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output stage_type                         dn_data
);

   logic                        valid_ff;
   stage_type                   data_ff;
   stage_type                   data_in;
   logic [COMPONENT_BITS:0]     wide_x;
   logic [COMPONENT_BITS:0]     wide_y;
   logic [COMPONENT_BITS:0]     wide_z;
   logic [COMPONENT_BITS-1:0]   mag_x;
   logic [COMPONENT_BITS-1:0]   mag_y;
   logic [COMPONENT_BITS-1:0]   mag_z;
   logic                        neg_x;
   logic                        neg_y;
   logic                        neg_z;

   assign neg_x = dir_x[COMPONENT_BITS-1];
   assign neg_y = dir_y[COMPONENT_BITS-1];
   assign neg_z = dir_z[COMPONENT_BITS-1];

   // One extra bit keeps the most negative component exact.
   assign wide_x = neg_x ? -{dir_x[COMPONENT_BITS-1], dir_x} : {dir_x[COMPONENT_BITS-1], dir_x};
   assign wide_y = neg_y ? -{dir_y[COMPONENT_BITS-1], dir_y} : {dir_y[COMPONENT_BITS-1], dir_y};
   assign wide_z = neg_z ? -{dir_z[COMPONENT_BITS-1], dir_z} : {dir_z[COMPONENT_BITS-1], dir_z};
   assign mag_x  = wide_x[COMPONENT_BITS-1:0];
   assign mag_y  = wide_y[COMPONENT_BITS-1:0];
   assign mag_z  = wide_z[COMPONENT_BITS-1:0];

   always_comb begin
      data_in       = '0;
      data_in.zero  = (mag_x == '0) && (mag_y == '0) && (mag_z == '0);
      // The sub flags combine the sign of the ratio with the sign the face applies to it.
      if ((mag_x > mag_y) && (mag_x > mag_z)) begin
         data_in.face  = neg_x ? FACE_NEG_X : FACE_POS_X;
         data_in.major = mag_x;
         data_in.rem_u = mag_z;
         data_in.rem_v = mag_y;
         data_in.u_sub = neg_z ^ neg_x;
         data_in.v_sub = !neg_y;
      end else if (mag_y > mag_z) begin
         data_in.face  = neg_y ? FACE_NEG_Y : FACE_POS_Y;
         data_in.major = mag_y;
         data_in.rem_u = mag_x;
         data_in.rem_v = mag_z;
         data_in.u_sub = neg_x;
         data_in.v_sub = !(neg_z ^ neg_y);
      end else begin
         data_in.face  = neg_z ? FACE_NEG_Z : FACE_POS_Z;
         data_in.major = mag_z;
         data_in.rem_u = mag_x;
         data_in.rem_v = mag_y;
         data_in.u_sub = (!neg_x && (mag_x != '0)) ^ neg_z;
         data_in.v_sub = !neg_y;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/cmfs_div_cell.sv =====
// Divider cell: retires one quotient bit of both the u and the v division.
module cmfs_div_cell
   import cmfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        first_cell,
   input  logic        up_valid,
   output logic        up_ready,
   input  stage_type   up_data,
   output logic        dn_valid,
   input  logic        dn_ready,
   output stage_type   dn_data
);

   logic                        valid_ff;
   stage_type                   data_ff;
   stage_type                   data_in;
   logic [COMPONENT_BITS:0]     trial_u;
   logic [COMPONENT_BITS:0]     trial_v;
   logic [COMPONENT_BITS:0]     diff_u;
   logic [COMPONENT_BITS:0]     diff_v;
   logic                        bit_u;
   logic                        bit_v;

   // The first cell compares the numerator itself, since it never exceeds the divisor.
   assign trial_u = first_cell ? {1'b0, up_data.rem_u} : {up_data.rem_u, 1'b0};
   assign trial_v = first_cell ? {1'b0, up_data.rem_v} : {up_data.rem_v, 1'b0};
   assign diff_u  = trial_u - {1'b0, up_data.major};
   assign diff_v  = trial_v - {1'b0, up_data.major};
   assign bit_u   = trial_u >= {1'b0, up_data.major};
   assign bit_v   = trial_v >= {1'b0, up_data.major};

   always_comb begin
      data_in       = up_data;
      data_in.rem_u = bit_u ? diff_u[COMPONENT_BITS-1:0] : trial_u[COMPONENT_BITS-1:0];
      data_in.rem_v = bit_v ? diff_v[COMPONENT_BITS-1:0] : trial_v[COMPONENT_BITS-1:0];
      data_in.quo_u = {up_data.quo_u[COORD_FRACTION_BITS-2:0], bit_u};
      data_in.quo_v = {up_data.quo_v[COORD_FRACTION_BITS-2:0], bit_v};
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/cmfs_output.sv =====
// Output stage: offsets the quotients from the face center and holds the response.
module cmfs_output
   import cmfs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         up_valid,
   output logic         up_ready,
   input  stage_type    up_data,
   output logic         dn_valid,
   input  logic         dn_ready,
   output result_type   dn_data
);

   logic                    valid_ff;
   result_type              data_ff;
   result_type              data_in;
   logic [COORD_BITS-1:0]   quo_u;
   logic [COORD_BITS-1:0]   quo_v;

   assign quo_u = {1'b0, up_data.quo_u};
   assign quo_v = {1'b0, up_data.quo_v};

   always_comb begin
      data_in.face = up_data.face;
      data_in.zero = up_data.zero;
      if (up_data.zero) begin
         data_in.coord_u = COORD_HALF;
         data_in.coord_v = COORD_HALF;
      end else begin
         data_in.coord_u = up_data.u_sub ? COORD_HALF - quo_u : COORD_HALF + quo_u;
         data_in.coord_v = up_data.v_sub ? COORD_HALF - quo_v : COORD_HALF + quo_v;
      end
   end

   assign up_ready = !valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// ===== rtl/cube_map_face_select.sv =====
// Top level of the cube map face selection block.
// Each request is a direction vector; the block answers with its cube face and the (u, v)
// texture coordinates on that face, one response per request, in order. It takes one
// request per clock while rsp_tready does not stall it; each request passes through the
// face choice register, one divider cell per quotient bit and then the output register.
// Every stage has its own valid bit, so empty stages keep taking requests while a response
// waits.
`include "cube_map_face_select_assert.svh"

module cube_map_face_select
   import cmfs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // dir_x, dir_y, dir_z (signed), zero fill
   input  logic [REQ_DATA_BITS-1:0]   req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // face, coord_u, coord_v, zero fill
   output logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   // zero_direction
   output logic                       rsp_tuser
);

   stage_type    chain_data  [0:COORD_FRACTION_BITS];
   logic         chain_valid [0:COORD_FRACTION_BITS];
   logic         chain_ready [0:COORD_FRACTION_BITS];
   result_type   rsp_data;

   cmfs_select u_select (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .dir_x    (req_tdata[COMPONENT_BITS-1:0]),
      .dir_y    (req_tdata[2*COMPONENT_BITS-1:COMPONENT_BITS]),
      .dir_z    (req_tdata[3*COMPONENT_BITS-1:2*COMPONENT_BITS]),
      .dn_valid (chain_valid[0]),
      .dn_ready (chain_ready[0]),
      .dn_data  (chain_data[0])
   );

   for (genvar i = 0; i < COORD_FRACTION_BITS; i++) begin : g_cell
      cmfs_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .first_cell (i == 0),
         .up_valid   (chain_valid[i]),
         .up_ready   (chain_ready[i]),
         .up_data    (chain_data[i]),
         .dn_valid   (chain_valid[i+1]),
         .dn_ready   (chain_ready[i+1]),
         .dn_data    (chain_data[i+1])
      );
   end

   cmfs_output u_output (
      .clock    (clock),
      .reset    (reset),
      .up_valid (chain_valid[COORD_FRACTION_BITS]),
      .up_ready (chain_ready[COORD_FRACTION_BITS]),
      .up_data  (chain_data[COORD_FRACTION_BITS]),
      .dn_valid (rsp_tvalid),
      .dn_ready (rsp_tready),
      .dn_data  (rsp_data)
   );

   assign rsp_tdata = RSP_DATA_BITS'({rsp_data.coord_v, rsp_data.coord_u, rsp_data.face});
   assign rsp_tuser = rsp_data.zero;

   `CMFS_ASSERT_IMPLY(a_face_code, clock, reset, rsp_tvalid, rsp_data.face <= FACE_POS_Z)
   `CMFS_ASSERT_IMPLY(a_zero_center, clock, reset, rsp_tvalid && rsp_tuser,
      rsp_data.coord_u == COORD_HALF && rsp_data.coord_v == COORD_HALF && rsp_data.face == FACE_POS_Z)
   `CMFS_ASSERT_IMPLY(a_coord_range, clock, reset, rsp_tvalid,
      rsp_data.coord_u <= COORD_ONE && rsp_data.coord_v <= COORD_ONE)
   `CMFS_ASSERT_IMPLY(a_ready_when_drained, clock, reset, !rsp_tvalid, req_tready)

endmodule
